// File: src/dpq_pkg.sv
// Package for the double-ended priority queue: types, codes and sizing constants.
package dpq_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int ENTRY_COUNT_W = 5;

	typedef enum logic [1:0] {
		REQ_INSERT  = 2'd0,
		REQ_DEL_MIN = 2'd1,
		REQ_DEL_MAX = 2'd2
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_REPORT
	} state_t;

	typedef struct packed {
		req_type_t          req_type;
		logic [31:0]        payload_in;
		logic signed [31:0] priority_in;
	} req_t;

	typedef struct packed {
		status_t                    status;
		logic [31:0]                payload_out;
		logic signed [31:0]         priority_out;
		logic signed [31:0]         min_priority;
		logic signed [31:0]         max_priority;
		logic [ENTRY_COUNT_W-1:0]   entry_count;
	} rsp_t;

	typedef struct packed {
		logic [31:0]        payload;
		logic signed [31:0] prio;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic exec;
		logic report;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic rsp_valid;
	} dp_status_t;

endpackage

// File: src/dpq_ctrl.sv
// Controller state machine: takes a transaction, then reports its result.
module dpq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic                rsp_stall,
	input  dpq_pkg::dp_status_t status,
	output dpq_pkg::dp_cmd_t    cmd
);
	import dpq_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd.exec   = 1'b0;
		cmd.report = 1'b0;
		req_stall  = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.exec = 1'b1;
					state_d  = S_REPORT;
				end
			end
			S_REPORT: begin
				// wait until the output register is free
				if (!(status.rsp_valid && rsp_stall)) begin
					cmd.report = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	ap_no_exec_in_report: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> state_q == S_REPORT && !cmd.exec)
		else $error("exec issued while a result was pending");

	ap_report_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.report |-> $past(cmd.exec) || $past(state_q) == S_REPORT)
		else $error("report without a preceding exec");

	ap_stall_in_report: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> req_stall)
		else $error("input not stalled while result pending");

endmodule

// File: src/dpq_datapath.sv
// Datapath: sorted compare-and-shift cell chain, fill count and output register.
module dpq_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  dpq_pkg::req_t       req,
	input  dpq_pkg::dp_cmd_t    cmd,
	output dpq_pkg::dp_status_t status,
	output dpq_pkg::rsp_t       rsp,
	output logic                rsp_valid,
	input  logic                rsp_stall
);
	import dpq_pkg::*;

	entry_t              cell_q [CAPACITY];
	entry_t              cell_d [CAPACITY];
	logic [CNT_W-1:0]    count_q;
	logic [CAPACITY-1:0] ge;
	logic [CNT_W-1:0]    last_c;
	logic [IDX_W-1:0]    last_idx;
	logic                full;
	logic                empty;
	status_t             stat_q;
	entry_t              removed_q;
	rsp_t                rsp_q;
	logic                rsp_valid_q;

	assign full     = count_q == CNT_W'(CAPACITY);
	assign empty    = count_q == '0;
	assign last_c   = count_q - CNT_W'(1);
	assign last_idx = last_c[IDX_W-1:0];

	// each valid cell flags whether it holds a priority at or above the new one
	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			assign ge[gi] = (CNT_W'(gi) < count_q) && (cell_q[gi].prio >= req.priority_in);
			if (gi == 0) begin : g_first
				always_comb begin
					cell_d[gi] = cell_q[gi];
					if (ge[gi] || empty) begin
						cell_d[gi].payload = req.payload_in;
						cell_d[gi].prio    = req.priority_in;
					end
				end
			end else begin : g_rest
				always_comb begin
					cell_d[gi] = cell_q[gi];
					if (ge[gi-1]) begin
						cell_d[gi] = cell_q[gi-1];
					end else if (ge[gi] || count_q == CNT_W'(gi)) begin
						cell_d[gi].payload = req.payload_in;
						cell_d[gi].prio    = req.priority_in;
					end
				end
			end

			always_ff @(posedge clk) begin
				if (cmd.exec) begin
					if (req.req_type == REQ_INSERT && !full) begin
						cell_q[gi] <= cell_d[gi];
					end else if (req.req_type == REQ_DEL_MIN && !empty) begin
						if (gi < CAPACITY - 1) begin
							cell_q[gi] <= cell_q[(gi < CAPACITY - 1) ? gi + 1 : gi];
						end
					end
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			case (req.req_type) inside
				REQ_INSERT: begin
					if (!full) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				REQ_DEL_MIN, REQ_DEL_MAX: begin
					if (!empty) begin
						count_q <= last_c;
					end
				end
				default: ;
			endcase
		end
	end

	// status and removed entry of the transaction just executed
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			stat_q    <= ST_OK;
			removed_q <= '0;
			case (req.req_type)
				REQ_INSERT: begin
					if (full) begin
						stat_q <= ST_FULL;
					end
				end
				REQ_DEL_MIN: begin
					if (empty) begin
						stat_q <= ST_EMPTY;
					end else begin
						removed_q <= cell_q[0];
					end
				end
				REQ_DEL_MAX: begin
					if (empty) begin
						stat_q <= ST_EMPTY;
					end else begin
						removed_q <= cell_q[last_idx];
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.report) begin
			rsp_q.status       <= stat_q;
			rsp_q.payload_out  <= removed_q.payload;
			rsp_q.priority_out <= removed_q.prio;
			rsp_q.min_priority <= empty ? '0 : cell_q[0].prio;
			rsp_q.max_priority <= empty ? '0 : cell_q[last_idx].prio;
			rsp_q.entry_count  <= ENTRY_COUNT_W'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.report) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp              = rsp_q;
	assign rsp_valid        = rsp_valid_q;
	assign status.rsp_valid = rsp_valid_q;

	ap_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("fill count beyond capacity");

	ap_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CNT_W'(2) |-> cell_q[0].prio <= cell_q[1].prio)
		else $error("head cells out of order");

	ap_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.report |=> rsp_q.min_priority <= rsp_q.max_priority)
		else $error("reported minimum above maximum");

	ap_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && req.req_type == REQ_INSERT && !full |=>
		count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow the count");

endmodule

// File: src/double_ended_priority_queue_top.sv
// A request is accepted and executed in the idle state; the report state then
// loads its result into the output register once that register is free.
// Requests are taken only in the idle state; all work happens in the cell chain.
// Reset: arst_n clears the fill count, controller state and output valid;
// cell contents stay undefined until written.
// Top level of the double-ended priority queue.
module double_ended_priority_queue_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  dpq_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output dpq_pkg::rsp_t  rsp
);
	import dpq_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	dpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_stall (rsp_stall),
		.status    (status),
		.cmd       (cmd)
	);

	dpq_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.status    (status),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall)
	);

endmodule

// File: bench/tb_double_ended_priority_queue_top.sv
// Self-checking testbench for the double-ended priority queue top level.
`timescale 1ns / 1ps

module tb_double_ended_priority_queue_top;
	import dpq_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 1680;
	localparam int CALM_ITEMS = 130;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// shadow copy of the queue contents, ascending priority
	entry_t held_entries[$];
	rsp_t pending_results[$];

	int mismatches = 0;
	int cycles = 0;
	int checked = 0;
	int n_requests = 0;
	int n_inserts = 0;
	int n_full = 0;
	int n_empty = 0;
	int gap_odds = 25;
	int stall_odds = 25;
	int stall_left = 0;
	bit calm = 1'b0;

	double_ended_priority_queue_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_results.size());
			$display("double_ended_priority_queue_top regression: fail");
			$finish;
		end
	end

	// works out the result of one request and updates the shadow queue
	function automatic rsp_t apply_request(req_t r);
		rsp_t o;
		entry_t e;
		int pos;
		o = '0;
		o.status = ST_OK;
		case (r.req_type) inside
			REQ_INSERT: begin
				if (held_entries.size() >= CAPACITY) begin
					o.status = ST_FULL;
				end else begin
					// new entry goes ahead of equal priorities
					pos = 0;
					while (pos < held_entries.size() &&
						$signed(held_entries[pos].prio) < $signed(r.priority_in))
						pos++;
					e.payload = r.payload_in;
					e.prio = r.priority_in;
					held_entries.insert(pos, e);
				end
			end
			REQ_DEL_MIN, REQ_DEL_MAX: begin
				if (held_entries.size() == 0) begin
					o.status = ST_EMPTY;
				end else begin
					e = (r.req_type == REQ_DEL_MIN) ? held_entries.pop_front()
						: held_entries.pop_back();
					o.payload_out = e.payload;
					o.priority_out = e.prio;
				end
			end
			default: ;
		endcase
		if (held_entries.size() != 0) begin
			o.min_priority = held_entries[0].prio;
			o.max_priority = held_entries[held_entries.size() - 1].prio;
		end
		o.entry_count = ENTRY_COUNT_W'(held_entries.size());
		return o;
	endfunction

	function automatic logic [31:0] random_priority();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000 + $urandom_range(0, 2);
			1: return 32'h7FFF_FFFF - $urandom_range(0, 2);
			// a handful of Q16.16 values so ties are common
			2: return (32'($urandom_range(0, 8)) - 32'd4) << 16;
			default: return $urandom;
		endcase
	endfunction

	task automatic issue_request(req_type_t kind, logic [31:0] tag, logic [31:0] prio);
		req_t r;
		rsp_t want;
		int n;
		r.req_type = kind;
		r.payload_in = tag;
		r.priority_in = prio;
		@(negedge clk);
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		want = apply_request(r);
		pending_results.push_back(want);
		n_requests++;
		if (kind == REQ_INSERT) n_inserts++;
		if (want.status == ST_FULL) n_full++;
		if (want.status == ST_EMPTY) n_empty++;
		if (!calm && $urandom_range(0, 99) < gap_odds) begin
			n = $urandom_range(1, 11);
			@(negedge clk) req_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic issue_random();
		issue_request(REQ_INSERT, $urandom, random_priority());
	endtask

	// receiver back-pressure in bursts
	always @(negedge clk) begin
		if (stall_left != 0) begin
			rsp_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (!calm && $urandom_range(0, 99) < stall_odds) begin
			rsp_stall <= 1'b1;
			stall_left <= $urandom_range(0, 10);
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on result %0d, %s: expected %08h, got %08h", checked, field,
				want, got);
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction at cycle %0d", cycles);
			end else begin
				want = pending_results.pop_front();
				if (rsp.status !== want.status)
					note_mismatch("status", 32'(want.status), 32'(rsp.status));
				if (rsp.payload_out !== want.payload_out)
					note_mismatch("payload_out", want.payload_out, rsp.payload_out);
				if (rsp.priority_out !== want.priority_out)
					note_mismatch("priority_out", want.priority_out, rsp.priority_out);
				if (rsp.min_priority !== want.min_priority)
					note_mismatch("min_priority", want.min_priority, rsp.min_priority);
				if (rsp.max_priority !== want.max_priority)
					note_mismatch("max_priority", want.max_priority, rsp.max_priority);
				if (rsp.entry_count !== want.entry_count)
					note_mismatch("entry_count", 32'(want.entry_count),
						32'(rsp.entry_count));
				checked++;
			end
		end
	end

	task automatic test_empty_deletes();
		issue_request(REQ_DEL_MIN, 32'h1234_5678, 32'h0001_0000);
		issue_request(REQ_DEL_MAX, 32'h8765_4321, 32'hFFFF_0000);
	endtask

	// extremes of tag and priority, ties at both ends and in the middle
	task automatic test_fill_to_capacity();
		issue_request(REQ_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		issue_request(REQ_INSERT, 32'h0000_0000, 32'h8000_0000);
		issue_request(REQ_INSERT, 32'h0000_0001, 32'h0000_0000);
		issue_request(REQ_INSERT, 32'h0000_0002, 32'h0000_0000);
		issue_request(REQ_INSERT, 32'h5555_5555, 32'h0001_8000);
		issue_request(REQ_INSERT, 32'hAAAA_AAAA, 32'hFFFE_8000);
		issue_request(REQ_INSERT, 32'h0000_0003, 32'h7FFF_FFFF);
		issue_request(REQ_INSERT, 32'h0000_0004, 32'h8000_0000);
		repeat (CAPACITY - 8) issue_request(REQ_INSERT, $urandom, $urandom);
	endtask

	task automatic test_full_insert();
		issue_request(REQ_INSERT, 32'hDEAD_BEEF, 32'h0000_0000);
	endtask

	// min end must give back the newest of the equal minima, max end the oldest
	task automatic test_end_removals();
		issue_request(REQ_DEL_MIN, 32'h0, 32'h0);
		issue_request(REQ_DEL_MAX, 32'h0, 32'h0);
	endtask

	task automatic run_random(int n_items);
		int done;
		int ins_pct;
		done = 0;
		while (done < n_items) begin
			// each segment drifts toward full, toward empty, or hovers
			case ($urandom_range(0, 3))
				0: ins_pct = 85;
				1: ins_pct = 15;
				default: ins_pct = $urandom_range(35, 65);
			endcase
			if (!calm) begin
				gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 50);
				stall_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 50);
			end
			repeat (40) begin
				if ($urandom_range(0, 99) < ins_pct)
					issue_random();
				else
					issue_request($urandom_range(0, 1) ? REQ_DEL_MIN : REQ_DEL_MAX,
						$urandom, $urandom);
				done++;
			end
		end
	endtask

	task automatic test_random_mix();
		run_random(RANDOM_ITEMS);
	endtask

	task automatic test_calm_traffic();
		calm = 1'b1;
		run_random(CALM_ITEMS);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		test_empty_deletes();
		test_fill_to_capacity();
		test_full_insert();
		test_end_removals();
		test_random_mix();
		test_calm_traffic();

		@(negedge clk) req_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d requests sent (%0d inserts), %0d refused as full, %0d as empty",
			n_requests, n_inserts, n_full, n_empty);
		$display("%0d results checked over %0d cycles, %0d mismatches", checked, cycles,
			mismatches);
		if (mismatches == 0)
			$display("double_ended_priority_queue_top regression: pass");
		else
			$display("double_ended_priority_queue_top regression: fail");
		$finish;
	end

endmodule
